### sv/sra_pkg.sv
package sra_pkg;

	// Fixed field widths
	localparam int unsigned COORD_W = 12;
	localparam int unsigned DIM_W   = 13;
	localparam int unsigned AREA_W  = 25;

	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	// Register reset value and configuration clamp bounds
	localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd512;
	localparam logic [DIM_W-1:0] DIM_MIN     = 13'd3;
	localparam logic [DIM_W-1:0] DIM_TOP     = 13'd4096;

	// Configuration register indexes
	typedef enum logic {
		REG_ATLAS_WIDTH  = 1'b0,
		REG_ATLAS_HEIGHT = 1'b1
	} reg_idx_t;

	// Operation codes carried in tuser
	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_CLEAR = 1'b1
	} func_t;

	// Result status codes
	typedef enum logic {
		ST_OK     = 1'b0,
		ST_NOROOM = 1'b1
	} status_t;

	// One skyline segment
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] level;
		logic [COORD_W-1:0] span;
	} seg_t;

	localparam int unsigned SEG_W = 3 * COORD_W;

	// Store control from the sequencer
	typedef struct packed {
		logic               swap;
		logic               reinit;
		logic [COORD_W-1:0] init_span;
	} store_ctl_t;

endpackage

### sv/sra_ram.sv
module sra_ram #(
	parameter int unsigned WIDTH = 36,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/sra_store.sv
module sra_store #(
	parameter int unsigned MAX_SEGMENTS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(MAX_SEGMENTS)-1:0] rd_addr,
	output sra_pkg::seg_t                   rd_data,
	input  logic                            wr_en,
	input  logic [$clog2(MAX_SEGMENTS)-1:0] wr_addr,
	input  sra_pkg::seg_t                   wr_data,
	input  sra_pkg::store_ctl_t             ctl,
	output logic                            fresh
);

	logic                       bank_q;
	logic                       fresh_q;
	logic [sra_pkg::COORD_W-1:0] init_span_q;
	logic [sra_pkg::SEG_W-1:0]  rdata0, rdata1;
	sra_pkg::seg_t              bank_data;

	// Bank select and the initial single-segment override
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			fresh_q     <= 1'b1;
			init_span_q <= sra_pkg::COORD_W'(sra_pkg::ATLAS_RESET - 13'd2);
		end else if (ctl.reinit) begin
			fresh_q     <= 1'b1;
			init_span_q <= ctl.init_span;
		end else if (ctl.swap) begin
			fresh_q <= 1'b0;
			bank_q  <= ~bank_q;
		end
	end

	// Read from the current bank, write the rebuilt list into the other
	sra_ram #(.WIDTH(sra_pkg::SEG_W), .DEPTH(MAX_SEGMENTS)) u_bank0 (
		.clk   (clk),
		.we    (wr_en & bank_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rdata0)
	);

	sra_ram #(.WIDTH(sra_pkg::SEG_W), .DEPTH(MAX_SEGMENTS)) u_bank1 (
		.clk   (clk),
		.we    (wr_en & ~bank_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rdata1)
	);

	assign bank_data = bank_q ? sra_pkg::seg_t'(rdata1) : sra_pkg::seg_t'(rdata0);

	// After reset or clear the only segment lives in registers
	always_comb begin
		if (fresh_q) begin
			rd_data.x     = sra_pkg::COORD_W'(1);
			rd_data.level = sra_pkg::COORD_W'(1);
			rd_data.span  = init_span_q;
		end else begin
			rd_data = bank_data;
		end
	end

	assign fresh = fresh_q;

endmodule

### sv/skyline_rect_allocator_unit.sv
// A clear or a refused request goes from idle straight to the result; an allocate runs the fit scan
// (each start reads forward until its width is covered, so up to n*(n+1)/2 reads for n
// segments), then rebuilds the skyline, evaluating each segment once and the chosen one twice,
// and finishes through the flush, area and done states.
// Throughput: one item at a time; s_tready returns after the result is loaded; a stalled
// result holds the block. Reset: one segment (1,1,510), area zero, both atlas registers 512.
module skyline_rect_allocator_unit #(
	parameter int unsigned MAX_SEGMENTS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [12:0] cfg_wdata,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // req_width[11:0], req_height[23:12]
	input  logic        s_tuser,  // func
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // status[0], region_x[12:1], region_y[24:13], used_area[49:25]
);

	localparam int unsigned AW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned CRD = sra_pkg::COORD_W;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCN_RD = 8'b0000_0010,
		S_SCN_EV = 8'b0000_0100,
		S_BLD_RD = 8'b0000_1000,
		S_BLD_EV = 8'b0001_0000,
		S_FLUSH  = 8'b0010_0000,
		S_AREA   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		PH_COPY = 2'd0,
		PH_TRIM = 2'd1,
		PH_REST = 2'd2
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [12:0] aw_q, ah_q, cfg_clamped;
	logic [CRD-1:0] w_q, h_q;
	logic [23:0] prod_q;
	logic [sra_pkg::AREA_W-1:0] area_q;
	logic [CW-1:0] count_q, wcount_q;
	logic [AW-1:0] idx_q, k_q, j_q, best_q;
	logic first_q, found_q, status_q;
	logic [CRD-1:0] row_q, best_row_q, best_span_q, best_x_q, start_span_q, start_x_q;
	logic signed [13:0] left_q;
	sra_pkg::seg_t pend_q;
	logic pend_v_q;

	logic [AW-1:0] rd_addr;
	sra_pkg::seg_t rd_data, wr_data;
	logic wr_en;
	sra_pkg::store_ctl_t ctl;
	logic fresh;

	// Clamp configuration writes into 3 .. 4096 (DIM_TOP)
	always_comb begin
		if (cfg_wdata < sra_pkg::DIM_MIN) begin
			cfg_clamped = sra_pkg::DIM_MIN;
		end else if (cfg_wdata > sra_pkg::DIM_TOP) begin
			cfg_clamped = sra_pkg::DIM_TOP;
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= sra_pkg::ATLAS_RESET;
			ah_q <= sra_pkg::ATLAS_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				sra_pkg::REG_ATLAS_WIDTH:  aw_q <= cfg_clamped;
				sra_pkg::REG_ATLAS_HEIGHT: ah_q <= cfg_clamped;
				default:                   aw_q <= aw_q;
			endcase
		end
	end

	// Shared evaluation unit: one segment per evaluation cycle
	sra_pkg::seg_t d;
	logic [12:0] x_end, top;
	logic [CRD-1:0] row_n, trim_end, start_span;
	logic signed [13:0] left_n, trim_span;
	logic fit_fail, fit_ok, last_k, better, last_idx, last_j;

	always_comb begin
		d          = rd_data;
		x_end      = {1'b0, d.x} + {1'b0, w_q};
		row_n      = (first_q || d.level > row_q) ? d.level : row_q;
		top        = {1'b0, row_n} + {1'b0, h_q};
		left_n     = (first_q ? $signed({2'b00, w_q}) : left_q) - $signed({2'b00, d.span});
		last_k     = (CW'(k_q) + CW'(1)) >= count_q;
		fit_fail   = (first_q && (x_end > aw_q - 13'd1)) || (top > ah_q - 13'd1)
		             || (left_n > 14'sd0 && last_k);
		fit_ok     = !fit_fail && (left_n <= 14'sd0);
		start_span = first_q ? d.span : start_span_q;
		better     = !found_q || (row_n < best_row_q) ||
		             (row_n == best_row_q && start_span < best_span_q);
		last_idx   = (CW'(idx_q) + CW'(1)) >= count_q;
		last_j     = (CW'(j_q) + CW'(1)) >= count_q;
		trim_end   = best_x_q + w_q;
		trim_span  = $signed({2'b00, d.x}) + $signed({2'b00, d.span})
		             - $signed({2'b00, trim_end});
	end

	// Segment produced by the rebuild in this cycle
	sra_pkg::seg_t emit;
	logic emit_v;

	always_comb begin
		emit   = d;
		emit_v = 1'b0;
		if (state_q == S_BLD_EV) begin
			case (phase_q)
				PH_COPY: begin
					emit_v = 1'b1;
					if (j_q == best_q) begin
						emit.x     = best_x_q;
						emit.level = CRD'(best_row_q + h_q);
						emit.span  = w_q;
					end
				end
				PH_TRIM: begin
					if (d.x < trim_end) begin
						emit_v     = trim_span > 14'sd0;
						emit.x     = trim_end;
						emit.span  = CRD'(trim_span);
					end else begin
						emit_v = 1'b1;
					end
				end
				default: emit_v = 1'b1;
			endcase
		end
	end

	// Merge equal neighbors into the pending segment before writing
	always_comb begin
		wr_en   = 1'b0;
		wr_data = pend_q;
		if (state_q == S_FLUSH) begin
			wr_en = 1'b1;
		end else if (emit_v && pend_v_q && pend_q.level != emit.level) begin
			wr_en = 1'b1;
		end
	end

	assign rd_addr = (state_q == S_SCN_RD || state_q == S_SCN_EV) ? k_q : j_q;

	always_comb begin
		ctl.swap      = (state_q == S_FLUSH);
		ctl.reinit    = (state_q == S_IDLE) && s_tvalid && (s_tuser == sra_pkg::FUNC_CLEAR);
		ctl.init_span = CRD'(aw_q - 13'd2);
	end

	sra_store #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (AW'(wcount_q)),
		.wr_data (wr_data),
		.ctl     (ctl),
		.fresh   (fresh)
	);

	assign s_tready = (state_q == S_IDLE);

	logic out_free;
	logic [sra_pkg::AREA_W:0] area_sum;
	assign out_free = !m_tvalid || m_tready;
	assign area_sum = {1'b0, area_q} + {2'b00, prod_q};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= PH_COPY;
			count_q  <= CW'(1);
			area_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			found_q  <= 1'b0;
			status_q <= sra_pkg::ST_OK;
			pend_v_q <= 1'b0;
			wcount_q <= '0;
		end else begin
			if (m_tvalid && m_tready && !(state_q == S_DONE && out_free)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						w_q      <= s_tdata[11:0];
						h_q      <= s_tdata[23:12];
						prod_q   <= s_tdata[11:0] * s_tdata[23:12];
						found_q  <= 1'b0;
						idx_q    <= '0;
						k_q      <= '0;
						first_q  <= 1'b1;
						best_x_q <= '0;
						best_row_q <= '0;
						if (s_tuser == sra_pkg::FUNC_CLEAR) begin
							count_q  <= CW'(1);
							area_q   <= '0;
							status_q <= sra_pkg::ST_OK;
							state_q  <= S_DONE;
						end else if (s_tdata[11:0] == '0 || s_tdata[23:12] == '0 ||
						             count_q == CW'(MAX_SEGMENTS)) begin
							status_q <= sra_pkg::ST_NOROOM;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCN_RD;
						end
					end
				end
				S_SCN_RD: state_q <= S_SCN_EV;
				S_SCN_EV: begin
					if (first_q) begin
						start_span_q <= d.span;
						start_x_q    <= d.x;
					end
					// a decided start re-arms the scan for the next one
					first_q <= fit_fail || fit_ok;
					row_q   <= row_n;
					left_q  <= left_n;
					if (fit_fail || fit_ok) begin
						if (fit_ok && better) begin
							found_q     <= 1'b1;
							best_q      <= idx_q;
							best_row_q  <= row_n;
							best_span_q <= start_span;
							best_x_q    <= first_q ? d.x : start_x_q;
						end
						if (last_idx) begin
							if (found_q || (fit_ok && better)) begin
								j_q      <= '0;
								wcount_q <= '0;
								pend_v_q <= 1'b0;
								phase_q  <= PH_COPY;
								state_q  <= S_BLD_RD;
							end else begin
								status_q <= sra_pkg::ST_NOROOM;
								state_q  <= S_DONE;
							end
						end else begin
							idx_q   <= idx_q + AW'(1);
							k_q     <= idx_q + AW'(1);
							state_q <= S_SCN_RD;
						end
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= S_SCN_RD;
					end
				end
				S_BLD_RD: state_q <= S_BLD_EV;
				S_BLD_EV: begin
					if (emit_v) begin
						pend_v_q <= 1'b1;
						if (pend_v_q && pend_q.level == emit.level) begin
							pend_q.span <= pend_q.span + emit.span;
						end else begin
							pend_q <= emit;
						end
						if (wr_en) begin
							wcount_q <= wcount_q + CW'(1);
						end
					end
					if (phase_q == PH_COPY && j_q == best_q) begin
						// Same entry again, now trimmed against the new segment
						phase_q <= PH_TRIM;
					end else begin
						if (phase_q == PH_TRIM && !(d.x < trim_end && trim_span <= 14'sd0)) begin
							phase_q <= PH_REST;
						end
						if (last_j) begin
							state_q <= S_FLUSH;
						end else begin
							j_q     <= j_q + AW'(1);
							state_q <= S_BLD_RD;
						end
					end
				end
				S_FLUSH: begin
					count_q  <= wcount_q + CW'(1);
					status_q <= sra_pkg::ST_OK;
					state_q  <= S_AREA;
				end
				S_AREA: begin
					area_q  <= (area_sum > {1'b0, sra_pkg::AREA_MAX}) ?
					           sra_pkg::AREA_MAX : area_sum[sra_pkg::AREA_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {6'd0, area_q,
						             (status_q == sra_pkg::ST_OK) ? best_row_q : {CRD{1'b0}},
						             (status_q == sra_pkg::ST_OK) ? best_x_q : {CRD{1'b0}},
						             status_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CW'(MAX_SEGMENTS))
		else $error("segment count out of range");

	a_fresh_single: assert property (@(posedge clk) disable iff (!arst_n)
		fresh |-> count_q == CW'(1))
		else $error("initial segment override with more than one segment");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCN_RD |-> CW'(k_q) < count_q)
		else $error("fit scan past the skyline end");

	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |=> count_q == $past(wcount_q) + CW'(1))
		else $error("rebuilt segment count mismatch");

	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wcount_q <= count_q)
		else $error("rebuild writes past one added segment");

endmodule
